// ----- rtl/aace_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aace_pkg;

	// Chunk id "01wb" as it reads little-endian off the byte stream.
	localparam logic [31:0] TAG_AUDIO = 32'h6277_3130;
	localparam int HDR_BYTES = 8;
	localparam int HCOUNT_W = $clog2(HDR_BYTES);

	// x / 100 == (x * DIV100_MAGIC) >> DIV100_SHIFT for every 32-bit x.
	localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
	localparam int DIV100_SHIFT = 37;
	localparam logic [6:0] VOL_UNITY = 7'd100;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] CFG_VOLUME = 2'd0;
	localparam logic [1:0] CFG_LIST_LENGTH = 2'd1;
	localparam logic [1:0] CFG_KEPT_LIMIT = 2'd2;

	localparam logic [6:0] VOLUME_RST = 7'd100;
	localparam logic [31:0] LIST_LENGTH_RST = 32'd0;
	localparam logic [16:0] KEPT_LIMIT_RST = 17'd4096;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               chunk_last;
	} out_item_t;

	typedef struct packed {
		logic [6:0]  volume_percent;
		logic [31:0] list_length;
		logic [16:0] kept_byte_limit;
	} cfg_regs_t;

	// One raw sample handed from the parser to the scaler.
	typedef struct packed {
		logic [15:0] raw;
		logic        last;
	} sample_job_t;

	typedef struct packed {
		logic full;
		logic avail;
	} queue_status_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_KEEP   = 3'b010,
		PH_SKIP   = 3'b100
	} phase_t;

endpackage

`default_nettype wire

// ----- rtl/aace_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aace_parser (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     take,
	input  aace_pkg::in_item_t      item,
	input  aace_pkg::cfg_regs_t     cfg,
	output logic                    push,
	output aace_pkg::sample_job_t   job
);

	aace_pkg::phase_t phase_q;
	logic [aace_pkg::HCOUNT_W-1:0] hcount_q;
	logic [32:0] pos_q;
	logic [16:0] keep_q;
	logic [32:0] skip_q;
	logic        half_q;
	logic        finished_q;
	logic [7:0]  low_q;
	logic [(aace_pkg::HDR_BYTES-1)*8-1:0] hdr_q;

	aace_pkg::phase_t cur_phase;
	aace_pkg::phase_t phase_n;
	logic [aace_pkg::HCOUNT_W-1:0] cur_hcount;
	logic [32:0] cur_pos;
	logic        cur_finished;
	logic [aace_pkg::HDR_BYTES*8-1:0] full_hdr;
	logic [31:0] tag;
	logic [31:0] len;
	logic        pad;
	logic [33:0] pos_plus8;
	logic [33:0] pos_sum;
	logic [32:0] pos_next;
	logic        exceed;
	logic        is_audio;
	logic [16:0] keep_n;
	logic [32:0] skip_n;

	aace_pkg::phase_t phase_d;
	logic [aace_pkg::HCOUNT_W-1:0] hcount_d;
	logic [32:0] pos_d;
	logic [16:0] keep_d;
	logic [32:0] skip_d;
	logic        half_d;
	logic        finished_d;

	localparam logic [aace_pkg::HCOUNT_W-1:0] HCOUNT_LAST =
		aace_pkg::HCOUNT_W'(aace_pkg::HDR_BYTES - 1);

	// A restart clears the parse state before its own byte is looked at.
	assign cur_phase    = item.restart ? aace_pkg::PH_HEADER : phase_q;
	assign cur_hcount   = item.restart ? '0 : hcount_q;
	assign cur_pos      = item.restart ? '0 : pos_q;
	assign cur_finished = item.restart ? 1'b0 : finished_q;

	assign full_hdr = {item.data_byte, hdr_q};
	assign tag = full_hdr[31:0];
	assign len = full_hdr[63:32];
	assign pad = len[0];

	assign pos_plus8 = {1'b0, cur_pos} + 34'(aace_pkg::HDR_BYTES);
	assign exceed    = pos_plus8 > {2'b00, cfg.list_length};
	assign pos_sum   = pos_plus8 + {2'b00, len} + {33'd0, pad};
	assign pos_next  = pos_sum[33] ? '1 : pos_sum[32:0];

	assign is_audio = (tag == aace_pkg::TAG_AUDIO) && (len != 32'd0);

	always_comb begin
		keep_n = '0;
		if (is_audio) begin
			keep_n = (len < {15'd0, cfg.kept_byte_limit}) ? len[16:0] : cfg.kept_byte_limit;
		end
		skip_n = {1'b0, len} - {16'd0, keep_n} + {32'd0, pad};
		if (keep_n != '0) begin
			phase_n = aace_pkg::PH_KEEP;
		end else if (skip_n != '0) begin
			phase_n = aace_pkg::PH_SKIP;
		end else begin
			phase_n = aace_pkg::PH_HEADER;
		end
	end

	always_comb begin
		phase_d    = cur_phase;
		hcount_d   = cur_hcount;
		pos_d      = cur_pos;
		keep_d     = keep_q;
		skip_d     = skip_q;
		half_d     = half_q;
		finished_d = cur_finished;
		if (!cur_finished) begin
			case (cur_phase)
				aace_pkg::PH_KEEP: begin
					half_d = !half_q;
					keep_d = keep_q - 17'd1;
					if (keep_q == 17'd1) begin
						// An unpaired trailing byte is simply dropped here.
						half_d  = 1'b0;
						phase_d = (skip_q != '0) ? aace_pkg::PH_SKIP : aace_pkg::PH_HEADER;
					end
				end
				aace_pkg::PH_SKIP: begin
					skip_d = skip_q - 33'd1;
					if (skip_q == 33'd1) begin
						phase_d = aace_pkg::PH_HEADER;
					end
				end
				default: begin
					if ((cur_hcount == '0) && exceed) begin
						finished_d = 1'b1;
					end else if (cur_hcount == HCOUNT_LAST) begin
						hcount_d = '0;
						pos_d    = pos_next;
						half_d   = 1'b0;
						keep_d   = keep_n;
						skip_d   = skip_n;
						phase_d  = phase_n;
					end else begin
						hcount_d = cur_hcount + 1'b1;
					end
				end
			endcase
		end
	end

	assign push = take && !cur_finished && (cur_phase == aace_pkg::PH_KEEP) && half_q;
	assign job.raw  = {item.data_byte, low_q};
	assign job.last = (keep_q == 17'd1) || (keep_q == 17'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= aace_pkg::PH_HEADER;
			hcount_q   <= '0;
			pos_q      <= '0;
			keep_q     <= '0;
			skip_q     <= '0;
			half_q     <= 1'b0;
			finished_q <= 1'b0;
		end else if (take) begin
			phase_q    <= phase_d;
			hcount_q   <= hcount_d;
			pos_q      <= pos_d;
			keep_q     <= keep_d;
			skip_q     <= skip_d;
			half_q     <= half_d;
			finished_q <= finished_d;
		end
	end

	// The eight header bytes are always consecutive transactions, so a plain
	// shift line over the last bytes holds the header when it completes.
	always_ff @(posedge clk) begin
		if (take) begin
			hdr_q <= full_hdr[aace_pkg::HDR_BYTES*8-1:8];
			if (!cur_finished && (cur_phase == aace_pkg::PH_KEEP) && !half_q) begin
				low_q <= item.data_byte;
			end
		end
	end

`ifndef ASSERT_OFF
	a_keep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == aace_pkg::PH_KEEP) |-> (keep_q != '0))
		else $error("keep phase with no bytes left to keep");
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == aace_pkg::PH_SKIP) |-> (skip_q != '0))
		else $error("skip phase with no bytes left to skip");
	a_finished_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q && !item.restart) |-> !push)
		else $error("sample produced after parsing ended");
`endif

endmodule

`default_nettype wire

// ----- rtl/aace_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aace_queue (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  aace_pkg::sample_job_t   push_job,
	input  wire                     pop,
	output aace_pkg::sample_job_t   head_job,
	output aace_pkg::queue_status_t status
);

	localparam int PTR_W = (aace_pkg::QUEUE_DEPTH > 1) ? $clog2(aace_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(aace_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(aace_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(aace_pkg::QUEUE_DEPTH);

	aace_pkg::sample_job_t slots_q [aace_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign status.full  = (count_q == CNT_FULL);
	assign status.avail = (count_q != '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && status.avail;
	assign head_job = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_job;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("sample pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> status.avail)
		else $error("sample popped from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count above its depth");
`endif

endmodule

`default_nettype wire

// ----- rtl/aace_scaler.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aace_scaler (
	input  wire                     clk,
	input  wire                     arst_n,
	input  aace_pkg::queue_status_t qstat,
	input  aace_pkg::sample_job_t   head_job,
	output logic                    pop,
	input  wire  [6:0]              volume_percent,
	output logic                    pcm_valid,
	input  wire                     pcm_ready,
	output aace_pkg::out_item_t     pcm_item
);

	logic        v_s1;
	logic [21:0] mag_s1;
	logic        neg_s1;
	logic        last_s1;
	logic        v_s2;
	logic [15:0] q_s2;
	logic        neg_s2;
	logic        last_s2;
	logic        valid_q;
	aace_pkg::out_item_t item_q;

	logic        adv_out;
	logic        en2;
	logic        en1;
	logic [6:0]  eff_vol;
	logic [15:0] mag;
	logic [21:0] scaled;
	logic [53:0] prod;

	assign adv_out = !valid_q || pcm_ready;
	assign en2 = !v_s2 || adv_out;
	assign en1 = !v_s1 || en2;
	assign pop = qstat.avail && en1;

	// Unity and above pass through: |s| * 100 / 100 is exact.
	assign eff_vol = (volume_percent >= aace_pkg::VOL_UNITY) ? aace_pkg::VOL_UNITY
		: volume_percent;
	assign mag    = head_job.raw[15] ? 16'(-head_job.raw) : head_job.raw;
	assign scaled = {6'd0, mag} * {15'd0, eff_vol};
	assign prod   = {32'd0, mag_s1} * {22'd0, aace_pkg::DIV100_MAGIC};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= qstat.avail;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			mag_s1  <= scaled;
			neg_s1  <= head_job.raw[15];
			last_s1 <= head_job.last;
		end
		if (en2) begin
			q_s2    <= prod[aace_pkg::DIV100_SHIFT +: 16];
			neg_s2  <= neg_s1;
			last_s2 <= last_s1;
		end
		if (adv_out) begin
			// Negating the magnitude truncates toward zero, as required.
			item_q.sample     <= neg_s2 ? $signed(16'(-q_s2)) : $signed(q_s2);
			item_q.chunk_last <= last_s2;
		end
	end

	assign pcm_valid = valid_q;
	assign pcm_item  = item_q;

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !neg_s2) |-> !q_s2[15])
		else $error("positive scaled sample out of range");
	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.avail)
		else $error("pop without a queued sample");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pcm_valid && !pcm_ready) |=> (pcm_valid && $stable(pcm_item)))
		else $error("output transaction changed while waiting");
`endif

endmodule

`default_nettype wire

// ----- rtl/avi_audio_chunk_extractor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Signals                              | Direction | Payload
// src     | src_valid, src_ready, src_item       | in        | one list byte, restart flag
// pcm     | pcm_valid, pcm_ready, pcm_item       | out       | scaled sample, chunk_last
// cfg     | cfg_valid, cfg_ready, cfg_index/data | in        | register write
//
// One byte is taken per cycle while src_ready is high; the high byte of a sample
// puts it into the queue, and it passes the three scaler stages before pcm_valid rises.
// The parser classifies every byte as it is taken; the scaler is a three-stage multiply,
// reciprocal multiply and sign restore pipeline behind a four-entry queue.
// Reset clears all parse state and loads the register defaults at once.
// src_ready drops only while the queue is full, which takes a stall on pcm.
// cfg_ready is always high.
module avi_audio_chunk_extractor (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  src_valid,
	output logic                 src_ready,
	input  aace_pkg::in_item_t   src_item,
	output logic                 pcm_valid,
	input  wire                  pcm_ready,
	output aace_pkg::out_item_t  pcm_item,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [1:0]           cfg_index,
	input  wire  [31:0]          cfg_data
);

	aace_pkg::cfg_regs_t     cfg_q;
	aace_pkg::queue_status_t qstat;
	aace_pkg::sample_job_t   push_job;
	aace_pkg::sample_job_t   head_job;
	logic take;
	logic push;
	logic pop;

	assign cfg_ready = 1'b1;
	assign src_ready = !qstat.full;
	assign take = src_valid && src_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume_percent  <= aace_pkg::VOLUME_RST;
			cfg_q.list_length     <= aace_pkg::LIST_LENGTH_RST;
			cfg_q.kept_byte_limit <= aace_pkg::KEPT_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				aace_pkg::CFG_VOLUME:      cfg_q.volume_percent  <= cfg_data[6:0];
				aace_pkg::CFG_LIST_LENGTH: cfg_q.list_length     <= cfg_data;
				aace_pkg::CFG_KEPT_LIMIT:  cfg_q.kept_byte_limit <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	aace_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (src_item),
		.cfg    (cfg_q),
		.push   (push),
		.job    (push_job)
	);

	aace_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (qstat)
	);

	aace_scaler u_scaler (
		.clk            (clk),
		.arst_n         (arst_n),
		.qstat          (qstat),
		.head_job       (head_job),
		.pop            (pop),
		.volume_percent (cfg_q.volume_percent),
		.pcm_valid      (pcm_valid),
		.pcm_ready      (pcm_ready),
		.pcm_item       (pcm_item)
	);

endmodule

`default_nettype wire

// ----- tb/avi_audio_chunk_extractor_tb.sv -----
`timescale 1ns / 1ps

module avi_audio_chunk_extractor_tb;

	localparam int CLK_PERIOD = 4;
	// Chunk id "01wb" read little-endian off the byte stream.
	localparam logic [31:0] AUDIO_ID = 32'h6277_3130;
	localparam logic [32:0] POS_LIMIT = 33'h1_FFFF_FFFF;
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int ITEM_BUDGET = 1300;
	localparam int HOLD_AT = 150;
	localparam int LONG_HOLD = 600;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic [2:0] {
		SCAN_HEADER = 3'b001,
		SCAN_KEEP   = 3'b010,
		SCAN_SKIP   = 3'b100
	} scan_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	aace_pkg::in_item_t src_item = '0;
	logic pcm_valid;
	logic pcm_ready = 1'b0;
	aace_pkg::out_item_t pcm_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	avi_audio_chunk_extractor uut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_item(src_item),
		.pcm_valid(pcm_valid),
		.pcm_ready(pcm_ready),
		.pcm_item(pcm_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	aace_pkg::in_item_t byte_stream[$];
	aace_pkg::out_item_t samples_due[$];
	int unsigned bytes_sent = 0;
	int unsigned bytes_taken = 0;
	int unsigned random_items = 0;
	int unsigned mismatches = 0;
	int unsigned samples_seen = 0;
	int unsigned stall_cycles = 0;
	bit list_start = 1'b0;
	bit stray_restarts = 1'b0;

	// Registers as the parser sees them.
	logic [6:0] gain_pct;
	logic [31:0] movi_len;
	logic [16:0] keep_cap;

	// Parser state.
	logic [32:0] list_pos;
	scan_phase_t scan;
	logic [2:0] hdr_cnt;
	logic [31:0] hdr_tag;
	logic [31:0] hdr_size;
	logic [16:0] keep_left;
	logic [32:0] skip_left;
	logic [7:0] low_hold;
	logic low_held;
	logic parse_done;

	function automatic void clear_parse();
		list_pos = '0;
		scan = SCAN_HEADER;
		hdr_cnt = '0;
		hdr_tag = '0;
		hdr_size = '0;
		keep_left = '0;
		skip_left = '0;
		low_hold = '0;
		low_held = 1'b0;
		parse_done = 1'b0;
	endfunction

	function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] d);
		case (idx)
			aace_pkg::CFG_VOLUME: gain_pct = d[6:0];
			aace_pkg::CFG_LIST_LENGTH: movi_len = d;
			aace_pkg::CFG_KEPT_LIMIT: keep_cap = d[16:0];
			default: ;
		endcase
	endfunction

	// The list position jumps by a whole chunk as soon as its header is complete.
	function automatic void close_header();
		logic [63:0] chunk_bytes;
		logic [63:0] pad;
		logic [63:0] nxt;
		logic [63:0] kept;
		logic [63:0] rest;
		chunk_bytes = {32'd0, hdr_size};
		pad = {63'd0, hdr_size[0]};
		nxt = {31'd0, list_pos} + 64'd8 + chunk_bytes + pad;
		list_pos = (nxt > {31'd0, POS_LIMIT}) ? POS_LIMIT : nxt[32:0];
		low_held = 1'b0;
		if (hdr_tag == AUDIO_ID && chunk_bytes != 0) begin
			kept = (chunk_bytes < {47'd0, keep_cap}) ? chunk_bytes : {47'd0, keep_cap};
		end else begin
			kept = '0;
		end
		rest = chunk_bytes - kept + pad;
		keep_left = kept[16:0];
		skip_left = rest[32:0];
		if (keep_left != 0)
			scan = SCAN_KEEP;
		else if (skip_left != 0)
			scan = SCAN_SKIP;
		else
			scan = SCAN_HEADER;
	endfunction

	function automatic void parse_byte(input aace_pkg::in_item_t it);
		logic [15:0] raw;
		int s;
		int v;
		aace_pkg::out_item_t want;
		if (it.restart)
			clear_parse();
		if (parse_done)
			return;
		case (scan)
			SCAN_KEEP: begin
				if (!low_held) begin
					low_hold = it.data_byte;
					low_held = 1'b1;
				end else begin
					raw = {it.data_byte, low_hold};
					s = $signed(raw);
					v = (gain_pct >= 7'd100) ? s : (s * int'(gain_pct)) / 100;
					low_held = 1'b0;
					want.sample = v[15:0];
					want.chunk_last = (keep_left - 17'd1) < 17'd2;
					samples_due.push_back(want);
				end
				keep_left = keep_left - 17'd1;
				if (keep_left == 0) begin
					low_held = 1'b0;
					scan = (skip_left != 0) ? SCAN_SKIP : SCAN_HEADER;
				end
			end
			SCAN_SKIP: begin
				skip_left = skip_left - 33'd1;
				if (skip_left == 0)
					scan = SCAN_HEADER;
			end
			default: begin
				if (hdr_cnt == 0) begin
					if ({31'd0, list_pos} + 64'd8 > {32'd0, movi_len}) begin
						parse_done = 1'b1;
						return;
					end
					hdr_tag = '0;
					hdr_size = '0;
				end
				if (hdr_cnt < 4)
					hdr_tag[8 * hdr_cnt +: 8] = it.data_byte;
				else
					hdr_size[8 * (hdr_cnt - 4) +: 8] = it.data_byte;
				if (hdr_cnt == 3'd7) begin
					hdr_cnt = '0;
					close_header();
				end else begin
					hdr_cnt = hdr_cnt + 3'd1;
				end
			end
		endcase
	endfunction

	// Byte source: a random gap after each item, with runs of back-to-back bytes.
	int unsigned src_gap = 0;
	bit src_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_item <= '0;
			src_gap <= 0;
		end else begin
			if (src_valid && src_ready) begin
				parse_byte(src_item);
				bytes_taken++;
			end
			if (src_valid && !src_ready) begin
				// Hold the offered byte until it is taken.
			end else if (src_gap != 0) begin
				src_valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (byte_stream.size() != 0) begin
				src_item <= byte_stream.pop_front();
				src_valid <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					src_burst = !src_burst;
				src_gap <= src_burst ? 0 : $urandom_range(0, 17);
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Sample sink: a random stall after each item, plus one long hold-off.
	int unsigned pcm_wait = 0;
	int unsigned hold_left = 0;
	bit pcm_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		aace_pkg::out_item_t want;
		if (!arst_n) begin
			pcm_ready <= 1'b0;
		end else begin
			if (pcm_valid && pcm_ready) begin
				samples_seen++;
				if (samples_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected sample %0d last %0b", $signed(pcm_item.sample),
							pcm_item.chunk_last);
				end else begin
					want = samples_due.pop_front();
					if (pcm_item.sample !== want.sample
							|| pcm_item.chunk_last !== want.chunk_last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("sample mismatch: expected %0d last %0b, got %0d last %0b",
								$signed(want.sample), want.chunk_last,
								$signed(pcm_item.sample), pcm_item.chunk_last);
					end
				end
				if (samples_seen == HOLD_AT)
					hold_left = LONG_HOLD;
				if ($urandom_range(0, 39) == 0)
					pcm_burst = !pcm_burst;
				pcm_wait = pcm_burst ? 0 : $urandom_range(0, 17);
			end
			if (hold_left != 0) begin
				hold_left--;
				pcm_ready <= 1'b0;
			end else if (pcm_wait != 0) begin
				pcm_wait--;
				pcm_ready <= 1'b0;
			end else begin
				pcm_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (src_valid && src_ready) || (pcm_valid && pcm_ready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, d);
		cfg_valid <= 1'b0;
	endtask

	// Half the writes carry junk above the register width.
	function automatic logic [31:0] with_stray_bits(input logic [31:0] v, input int w);
		logic [31:0] r;
		r = $urandom;
		if ($urandom_range(0, 1) == 0)
			r = '0;
		return (r << w) | v;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		aace_pkg::in_item_t it;
		it.data_byte = b;
		it.restart = list_start || (stray_restarts && $urandom_range(0, 199) == 0);
		list_start = 1'b0;
		byte_stream.push_back(it);
		bytes_sent++;
	endtask

	task automatic push_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			push_byte(w[8 * i +: 8]);
	endtask

	// Mostly well-formed chunks; some are cut short, some have huge sizes.
	task automatic push_list(input int unsigned target);
		int unsigned used;
		int unsigned chunk_len;
		int unsigned body;
		logic [31:0] id;
		bit cut;
		list_start = 1'b1;
		used = 0;
		while (used < target) begin
			case ($urandom_range(0, 9))
				0, 1: id = AUDIO_ID ^ (32'd1 << $urandom_range(0, 31));
				2: id = $urandom;
				default: id = AUDIO_ID;
			endcase
			case ($urandom_range(0, 19))
				0: chunk_len = 0;
				1: chunk_len = $urandom;
				2, 3, 4: chunk_len = $urandom_range(1, 3);
				default: chunk_len = $urandom_range(4, 48);
			endcase
			cut = (chunk_len > 48) || ($urandom_range(0, 14) == 0);
			if (chunk_len > 48)
				body = $urandom_range(0, 30);
			else if (cut)
				body = $urandom_range(0, chunk_len);
			else
				body = chunk_len + chunk_len % 2;
			push_word(id);
			push_word(chunk_len);
			for (int i = 0; i < body; i++)
				push_byte(8'($urandom_range(0, 255)));
			used += 8 + body;
			if (cut)
				break;
		end
		repeat ($urandom_range(0, 6))
			push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		while (bytes_taken != bytes_sent || samples_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic run_phase(input int k);
		logic [6:0] vol;
		logic [16:0] cap;
		logic [31:0] len;
		int unsigned target;
		int unsigned lists;
		int unsigned mark;
		target = $urandom_range(24, 160);
		case (k)
			0: vol = 7'd0;
			1: vol = 7'd127;
			2: vol = 7'd1;
			3: vol = 7'd99;
			4: vol = 7'd100;
			default: vol = ($urandom_range(0, 3) == 0) ? 7'd100 : 7'($urandom_range(0, 127));
		endcase
		case (k)
			0: cap = 17'd0;
			1: cap = 17'd1;
			2: cap = 17'd131071;
			3: cap = 17'd65536;
			4: cap = 17'd2;
			default: cap = ($urandom_range(0, 4) == 0) ? 17'd4096 : 17'($urandom_range(2, 40));
		endcase
		case (k)
			0: len = target + 4;
			1: len = 32'hFFFF_FFFF;
			2: len = target;
			3: len = 32'd0;
			4: len = target - 3;
			default: begin
				if ($urandom_range(0, 9) == 0)
					len = 32'hFFFF_FFFF;
				else
					len = target + $urandom_range(0, 12) - 4;
			end
		endcase
		write_reg(aace_pkg::CFG_VOLUME, with_stray_bits(vol, 7));
		write_reg(aace_pkg::CFG_LIST_LENGTH, len);
		write_reg(aace_pkg::CFG_KEPT_LIMIT, with_stray_bits(cap, 17));
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_SPARE, $urandom);
		mark = bytes_sent;
		if (len == 0) begin
			push_list(12);
		end else begin
			lists = $urandom_range(1, 3);
			repeat (lists)
				push_list(target);
			random_items += bytes_sent - mark;
		end
		wait_drained();
	endtask

	initial begin
		int k;
		gain_pct = 7'd100;
		movi_len = 32'd0;
		keep_cap = 17'd4096;
		clear_parse();
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed list: an odd audio chunk with both sample extremes and a dropped
		// trailing byte, a padded non-audio chunk, then the end of the list.
		write_reg(aace_pkg::CFG_VOLUME, with_stray_bits(7'd100, 7));
		write_reg(aace_pkg::CFG_LIST_LENGTH, 32'd30);
		write_reg(aace_pkg::CFG_KEPT_LIMIT, 32'd4096);
		write_reg(CFG_SPARE, $urandom);
		list_start = 1'b1;
		push_word(AUDIO_ID);
		push_word(32'd5);
		push_byte(8'hFF);
		push_byte(8'h7F);
		push_byte(8'h00);
		push_byte(8'h80);
		push_byte(8'hAA);
		push_byte(8'h5A);
		push_word(32'h6364_3030);
		push_word(32'd1);
		push_byte(8'h11);
		push_byte(8'h00);
		push_byte(8'hEE);
		wait_drained();

		stray_restarts = 1'b1;
		k = 0;
		while (random_items < ITEM_BUDGET) begin
			run_phase(k);
			k++;
		end

		if (mismatches == 0 && samples_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/aace_pkg.sv
rtl/aace_parser.sv
rtl/aace_queue.sv
rtl/aace_scaler.sv
rtl/avi_audio_chunk_extractor.sv
tb/avi_audio_chunk_extractor_tb.sv
